### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Signal that must never be high outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### design/mpe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape package
// Types, constants and helper functions shared by the escape-time block.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam int PIX_W     = 10;
	localparam int Q_W       = 32;
	localparam int STEP_W    = 31;
	localparam int ITER_W    = 16;
	localparam int MAG_W     = 34;
	localparam int DELTA_W   = PIX_W + STEP_W;
	localparam int SUM_W     = DELTA_W + 1;
	localparam int PROD_W    = 2 * Q_W;
	localparam int FRAC      = 28;

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;

	localparam int Q_DEPTH   = 2;
	localparam int QA_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W      = $clog2(Q_DEPTH + 1);

	localparam logic [PROD_W-1:0] FOUR_Q56    = 64'h0400_0000_0000_0000;
	localparam logic [MAG_W-1:0]  MAG_MAX     = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0]  MAG_FOUR_Q28 = 34'h0_4000_0000;

	localparam logic signed [Q_W-1:0]  RST_ORIGIN_RE = -32'sd402653184;
	localparam logic signed [Q_W-1:0]  RST_ORIGIN_IM = 32'sd402653184;
	localparam logic [STEP_W-1:0]      RST_STEP      = 31'd805306;
	localparam logic [ITER_W-1:0]      RST_MAX_ITERS = 16'd100;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_RE = 2'd0,
		REG_ORIGIN_IM = 2'd1,
		REG_STEP      = 2'd2,
		REG_MAX_ITERS = 2'd3
	} reg_idx_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_UPD
	} core_state_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]  out_x;
		logic [PIX_W-1:0]  out_y;
		logic [ITER_W-1:0] iter_count;
		logic [MAG_W-1:0]  magnitude_sq;
		logic              escaped;
	} pix_out_t;

	typedef struct packed {
		logic signed [Q_W-1:0] origin_re;
		logic signed [Q_W-1:0] origin_im;
		logic [STEP_W-1:0]     step;
		logic [ITER_W-1:0]     max_iters;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]      x;
		logic [PIX_W-1:0]      y;
		logic signed [Q_W-1:0] c_re;
		logic signed [Q_W-1:0] c_im;
	} c_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[SUM_W-1:Q_W-1];
		all_zero = ~|v[SUM_W-1:Q_W-1];
		if (all_one || all_zero) begin
			sat_q = v[Q_W-1:0];
		end else if (v[SUM_W-1]) begin
			sat_q = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			sat_q = {1'b0, {(Q_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [MAG_W-1:0] mag_out(input logic [PROD_W-1:0] q56);
		if (|q56[PROD_W-1:FRAC+MAG_W]) begin
			mag_out = MAG_MAX;
		end else begin
			mag_out = q56[FRAC+MAG_W-1:FRAC];
		end
	endfunction

endpackage

### design/mpe_fifo.sv
// ----------------------------------------------------------------------------
// Point queue
// Short first-in first-out queue that holds mapped points between the
// coordinate front end and the iteration core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_fifo
	import mpe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  c_item_t push_data,
	input  logic    pop,
	output c_item_t pop_data,
	output q_stat_t stat
);

	c_item_t         mem_q [Q_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] cnt_q;

	function automatic logic [QA_W-1:0] next_ptr(input logic [QA_W-1:0] p);
		if (p == QA_W'(Q_DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QC_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	`ASSERT_CLK(a_cnt_bound, cnt_q <= QC_W'(Q_DEPTH), "queue count exceeds depth")

endmodule

### design/mpe_front.sv
// ----------------------------------------------------------------------------
// Coordinate front end
// Accepts pixel requests, maps each pixel to its point c in Q4.28 with
// saturation, and pushes the point into the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_front
	import mpe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    start,
	output logic    busy,
	input  pix_in_t pixel,
	input  q_stat_t q_stat,
	output logic    push,
	output c_item_t push_data
);

	logic               valid_s1;
	logic [PIX_W-1:0]   x_s1;
	logic [PIX_W-1:0]   y_s1;
	logic [DELTA_W-1:0] dx_s1;
	logic [DELTA_W-1:0] dy_s1;
	logic               valid_s2;
	c_item_t            item_s2;

	logic                    accept;
	logic                    s2_free;
	logic                    advance;
	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;

	assign push    = valid_s2 && !q_stat.full;
	assign s2_free = !valid_s2 || push;
	assign advance = valid_s1 && s2_free;
	assign busy    = valid_s1 && !s2_free;
	assign accept  = start && !busy;

	assign sum_re = {{(SUM_W-Q_W){cfg.origin_re[Q_W-1]}}, cfg.origin_re}
		+ $signed({1'b0, dx_s1});
	assign sum_im = {{(SUM_W-Q_W){cfg.origin_im[Q_W-1]}}, cfg.origin_im}
		- $signed({1'b0, dy_s1});

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= pixel.pixel_x;
			y_s1  <= pixel.pixel_y;
			dx_s1 <= DELTA_W'(pixel.pixel_x) * DELTA_W'(cfg.step);
			dy_s1 <= DELTA_W'(pixel.pixel_y) * DELTA_W'(cfg.step);
		end
		if (advance) begin
			item_s2.x    <= x_s1;
			item_s2.y    <= y_s1;
			item_s2.c_re <= sat_q(sum_re);
			item_s2.c_im <= sat_q(sum_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !push);
		end
	end

	assign push_data = item_s2;

	`ASSERT_CLK(a_push_room, push |-> !q_stat.full, "push into a full queue")

endmodule

### design/mpe_core.sv
// ----------------------------------------------------------------------------
// Iteration core
// Pops mapped points and runs the escape-time recurrence; each pass steps
// through square, combine, then test and update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpe_core
	import mpe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  q_stat_t  q_stat,
	input  c_item_t  pop_data,
	output logic     pop,
	output logic     done,
	output pix_out_t result
);

	core_state_t state_q;
	core_state_t state_d;

	c_item_t                  item_q;
	logic signed [Q_W-1:0]    zr_q;
	logic signed [Q_W-1:0]    zi_q;
	logic [ITER_W-1:0]        count_q;
	logic signed [PROD_W-1:0] r2_q;
	logic signed [PROD_W-1:0] i2_q;
	logic signed [PROD_W-1:0] ri_q;
	logic [PROD_W-1:0]        mag_q;
	logic signed [PROD_W-1:0] diff_q;
	logic signed [PROD_W-1:0] rip_q;
	pix_out_t                 res_q;
	logic                     done_q;

	logic                    limit_hit;
	logic                    over_four;
	logic                    finish;
	logic                    upd;
	logic signed [SUM_W-1:0] new_re;
	logic signed [SUM_W-1:0] new_im;
	logic                    esc_done;

	assign limit_hit = (count_q == cfg.max_iters);
	assign over_four = (mag_q > FOUR_Q56);

	assign new_re = {{(SUM_W-(PROD_W-FRAC)){diff_q[PROD_W-1]}}, diff_q[PROD_W-1:FRAC]}
		+ {{(SUM_W-Q_W){item_q.c_re[Q_W-1]}}, item_q.c_re};
	assign new_im = {{(SUM_W-(PROD_W-FRAC+1)){rip_q[PROD_W-1]}}, rip_q[PROD_W-1:FRAC-1]}
		+ {{(SUM_W-Q_W){item_q.c_im[Q_W-1]}}, item_q.c_im};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (limit_hit || over_four) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_MUL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		finish = 1'b0;
		upd    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = !q_stat.empty;
			end
			ST_UPD: begin
				finish = limit_hit || over_four;
				upd    = !(limit_hit || over_four);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q  <= pop_data;
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (upd) begin
			zr_q    <= sat_q(new_re);
			zi_q    <= sat_q(new_im);
			count_q <= count_q + 1'b1;
		end
		r2_q   <= zr_q * zr_q;
		i2_q   <= zi_q * zi_q;
		ri_q   <= zr_q * zi_q;
		mag_q  <= $unsigned(r2_q) + $unsigned(i2_q);
		diff_q <= r2_q - i2_q;
		rip_q  <= ri_q;
		if (finish) begin
			res_q.out_x        <= item_q.x;
			res_q.out_y        <= item_q.y;
			res_q.iter_count   <= count_q;
			res_q.magnitude_sq <= mag_out(mag_q);
			res_q.escaped      <= !limit_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign done     = done_q;
	assign result   = res_q;
	assign esc_done = done && result.escaped;

	`ASSERT_CLK(a_done_pulse, done |=> !done, "result strobe held for two cycles")
	`ASSERT_CLK(a_esc_mag, esc_done |-> (result.magnitude_sq >= MAG_FOUR_Q28), "escape below four")
	`ASSERT_CLK(a_pop_nonempty, pop |-> !q_stat.empty, "pop from an empty queue")

endmodule

### design/mandelbrot_pixel_escape_top.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape-time engine
// Maps pixels to points of the complex plane and reports escape counts.
// ----------------------------------------------------------------------------
// Usage: software programs origin_re, origin_im, step and max_iters over the
// APB port (byte addresses 0, 4, 8, 12) while the engine is idle. A pixel
// request is taken at a rising edge where start is high and busy is low.
// Each request yields one result on the result port, marked by done for
// exactly one cycle; the receiver has no way to hold it off.
// The front end maps the pixel in its s1 and s2 registers and pushes the
// point into a two-entry queue, so it keeps taking requests while the core
// iterates until the queue and both registers are full. Each core pass takes
// the products zr*zr, zi*zi and zr*zi, then their sum and difference, then
// the test-and-update step. Each pixel runs n passes (its escape count, or
// max_iters without escape); the core pops a new point from the queue only
// after finishing the last.
// Reset clears the queue and pipeline and loads the default view.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_top
	import mpe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  pix_in_t            pixel,
	output logic               done,
	output pix_out_t           result
);

	cfg_t       cfg_q;
	reg_idx_e_t reg_idx;
	logic       wr_en;
	q_stat_t    q_stat;
	logic       push;
	c_item_t    push_data;
	logic       pop;
	c_item_t    pop_data;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_e_t'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re <= RST_ORIGIN_RE;
			cfg_q.origin_im <= RST_ORIGIN_IM;
			cfg_q.step      <= RST_STEP;
			cfg_q.max_iters <= RST_MAX_ITERS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ORIGIN_RE: cfg_q.origin_re <= pwdata;
				REG_ORIGIN_IM: cfg_q.origin_im <= pwdata;
				REG_STEP:      cfg_q.step      <= pwdata[STEP_W-1:0];
				REG_MAX_ITERS: cfg_q.max_iters <= pwdata[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_RE: prdata = cfg_q.origin_re;
			REG_ORIGIN_IM: prdata = cfg_q.origin_im;
			REG_STEP:      prdata = PDATA_W'(cfg_q.step);
			REG_MAX_ITERS: prdata = PDATA_W'(cfg_q.max_iters);
			default:       prdata = '0;
		endcase
	end

	mpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	mpe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule

### test/mandelbrot_pixel_escape_checker.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape checker
// Watches the register port, the pixel request channel and the result
// channel. Each accepted request is run through an escape-time predictor
// using the register values in force, and each result is compared field by
// field with the oldest waiting prediction.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_checker
	import mpe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  pix_in_t            pixel,
	input  logic               done,
	input  pix_out_t           result,
	output int                 error_count,
	output int                 outstanding,
	output int                 pixels_checked,
	output int                 escaped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	cfg_t     view;
	pix_out_t expected_results[$];
	int       reported;

	function automatic longint clamp_q(input longint v);
		if (v > longint'(32'sh7FFF_FFFF)) begin
			return longint'(32'sh7FFF_FFFF);
		end else if (v < -longint'(64'sh8000_0000)) begin
			return -longint'(64'sh8000_0000);
		end
		return v;
	endfunction

	function automatic pix_out_t escape_time(input pix_in_t p, input cfg_t v);
		pix_out_t    o;
		longint      c_re;
		longint      c_im;
		longint      z_re;
		longint      z_im;
		longint      re_sq;
		longint      im_sq;
		longint      re_im;
		logic [63:0] mag;
		logic [63:0] scaled;
		int unsigned passes;
		logic        esc;
		c_re = clamp_q(longint'(v.origin_re) + longint'(p.pixel_x) * longint'(v.step));
		c_im = clamp_q(longint'(v.origin_im) - longint'(p.pixel_y) * longint'(v.step));
		z_re = 0;
		z_im = 0;
		passes = 0;
		esc = 1'b0;
		mag = '0;
		while (!esc && passes < int'(v.max_iters)) begin
			re_sq = z_re * z_re;
			im_sq = z_im * z_im;
			re_im = z_re * z_im;
			mag = 64'(re_sq) + 64'(im_sq);
			if (mag > FOUR_Q56) begin
				esc = 1'b1;
			end else begin
				z_re = clamp_q(((re_sq - im_sq) >>> FRAC) + c_re);
				z_im = clamp_q((re_im >>> (FRAC - 1)) + c_im);
				passes++;
			end
		end
		if (!esc && passes > 0) begin
			mag = 64'(z_re * z_re) + 64'(z_im * z_im);
		end
		scaled = mag >> FRAC;
		o.out_x        = p.pixel_x;
		o.out_y        = p.pixel_y;
		o.iter_count   = passes[ITER_W-1:0];
		o.magnitude_sq = (scaled > 64'(MAG_MAX)) ? MAG_MAX : scaled[MAG_W-1:0];
		o.escaped      = esc;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			view = '{origin_re: RST_ORIGIN_RE, origin_im: RST_ORIGIN_IM,
				step: RST_STEP, max_iters: RST_MAX_ITERS};
			expected_results.delete();
			error_count = 0;
			outstanding = 0;
			pixels_checked = 0;
			escaped_seen = 0;
			reported = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_e_t'(paddr[3:2]))
					REG_ORIGIN_RE: view.origin_re = pwdata;
					REG_ORIGIN_IM: view.origin_im = pwdata;
					REG_STEP:      view.step = pwdata[STEP_W-1:0];
					REG_MAX_ITERS: view.max_iters = pwdata[ITER_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (reported < REPORT_MAX) begin
						reported++;
						$display("%0t: unexpected result x=%0d y=%0d iter=%0d mag=%h esc=%0b",
							$realtime, result.out_x, result.out_y, result.iter_count,
							result.magnitude_sq, result.escaped);
					end
				end else begin
					want = expected_results.pop_front();
					outstanding--;
					pixels_checked++;
					if (result.escaped === 1'b1) begin
						escaped_seen++;
					end
					if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
							result.iter_count !== want.iter_count ||
							result.magnitude_sq !== want.magnitude_sq ||
							result.escaped !== want.escaped) begin
						error_count++;
						if (reported < REPORT_MAX) begin
							reported++;
							$display("%0t: expected x=%0d y=%0d iter=%0d mag=%h esc=%0b",
								$realtime, want.out_x, want.out_y, want.iter_count,
								want.magnitude_sq, want.escaped);
							$display("%0t: actual   x=%0d y=%0d iter=%0d mag=%h esc=%0b",
								$realtime, result.out_x, result.out_y, result.iter_count,
								result.magnitude_sq, result.escaped);
						end
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(escape_time(pixel, view));
				outstanding++;
			end
		end
	end

endmodule

### test/mandelbrot_pixel_escape_top_tb.sv
// ----------------------------------------------------------------------------
// Mandelbrot pixel escape testbench
// Programs a series of views over the register port, from saturating corner
// cases to random windows of the plane, and sends pixel requests with random
// gaps. A checker beside the block predicts every result; this module only
// produces stimulus, runs a watchdog and reports the verdict.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_top_tb
	import mpe_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 153;
	localparam int QUIET_LIMIT  = 600000;
	localparam int CALM_PHASE   = 4;

	typedef enum int {
		VIEW_SET,
		VIEW_ZOOM,
		VIEW_WIDE,
		VIEW_COARSE
	} view_kind_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start;
	logic               busy;
	pix_in_t            pixel;
	logic               done;
	pix_out_t           result;

	int error_count;
	int outstanding;
	int pixels_checked;
	int escaped_seen;
	int quiet_cycles = 0;
	int views_run = 0;
	bit idle_on = 1'b1;

	mandelbrot_pixel_escape_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.pixel   (pixel),
		.done    (done),
		.result  (result)
	);

	mandelbrot_pixel_escape_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.pixel          (pixel),
		.done           (done),
		.result         (result),
		.error_count    (error_count),
		.outstanding    (outstanding),
		.pixels_checked (pixels_checked),
		.escaped_seen   (escaped_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input reg_idx_e_t idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_view(input logic [31:0] o_re, input logic [31:0] o_im,
			input logic [STEP_W-1:0] stp, input logic [ITER_W-1:0] lim);
		apb_write(REG_ORIGIN_RE, o_re);
		apb_write(REG_ORIGIN_IM, o_im);
		apb_write(REG_STEP, PDATA_W'(stp));
		apb_write(REG_MAX_ITERS, PDATA_W'(lim));
		views_run++;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		if (idle_on && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= '{pixel_x: x, pixel_y: y};
		do @(posedge clk); while (busy);
	endtask

	// Holds off new requests until every pending result has come back.
	task automatic drain_requests();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		view_kind_t        kind;
		logic [31:0]       o_re;
		logic [31:0]       o_im;
		logic [STEP_W-1:0] stp;
		logic [ITER_W-1:0] lim;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		pixel = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'h2AA, 10'h155);
		send_pixel(10'h155, 10'h2AA);
		drain_requests();

		set_view(RST_ORIGIN_RE, RST_ORIGIN_IM, RST_STEP, 16'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain_requests();

		set_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 16'hFFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain_requests();

		set_view(32'h0000_0000, 32'h0000_0000, 31'd0, 16'hFFFF);
		send_pixel(10'd1023, 10'd1023);
		drain_requests();

		set_view(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 16'd1);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain_requests();

		set_view(32'hE000_0000, 32'h0000_0000, 31'd1, 16'd200);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1, 10'd0);
		drain_requests();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			kind = view_kind_t'($urandom_range(0, 3));
			case (kind)
				VIEW_SET: begin
					o_re = 32'hD800_0000 + $urandom_range(0, 32'h2000_0000);
					o_im = 32'h0800_0000 + $urandom_range(0, 32'h1000_0000);
					stp = STEP_W'($urandom_range(32'h1_0000, 32'h10_0000));
					lim = ITER_W'($urandom_range(16, 80));
				end
				VIEW_ZOOM: begin
					o_re = 32'hF400_0000 + $urandom_range(0, 32'h100_0000);
					o_im = $urandom_range(0, 32'h800_0000);
					stp = STEP_W'($urandom_range(1, 32'h1000));
					lim = ITER_W'($urandom_range(8, 64));
				end
				VIEW_WIDE: begin
					o_re = $urandom;
					o_im = $urandom;
					stp = STEP_W'($urandom);
					lim = ITER_W'($urandom_range(1, 64));
				end
				default: begin
					o_re = $urandom;
					o_im = $urandom;
					stp = STEP_W'($urandom_range(32'h4_0000, 32'h40_0000));
					lim = ITER_W'($urandom_range(1, 255));
				end
			endcase
			set_view(o_re, o_im, stp, lim);
			idle_on = (ph != CALM_PHASE);
			repeat (PHASE_ITEMS) begin
				send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
			end
			drain_requests();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d pixel requests over %0d register settings (%0d escaped).",
			pixels_checked, views_run, escaped_seen);
		$display("Views ranged from saturated corners and a zero limit to random windows.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
